// ----- rtl/bfo_pkg.sv -----
// Package for the byte FIFO with overflow policy.
// Field widths, register, action and mode codes, default sizes. No dependencies.
package bfo_pkg;

  localparam int CNT_W          = 11;
  localparam int CFG_W          = 11;
  localparam int MODE_W         = 2;
  localparam int ACT_W          = 3;
  localparam int BYTE_W         = 8;
  localparam int DISC_W         = 16;
  localparam int DROP_W         = 32;
  localparam int CFG_IDX_W      = 1;
  localparam int STORE_DEPTH_DF = 1024;
  localparam int CAP_RESET      = 1024;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH    = 3'd0,
    ACT_POP     = 3'd1,
    ACT_PEEK    = 3'd2,
    ACT_DISCARD = 3'd3,
    ACT_CLEAR   = 3'd4
  } action_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_BLOCK    = 2'd0,
    MODE_DROP_NEW = 2'd1,
    MODE_DROP_OLD = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 1'd1;

endpackage

// ----- rtl/bfo_in_if.sv -----
// Request channel of the byte FIFO: valid, ready and one action word.
// Depends on bfo_pkg.
interface bfo_in_if import bfo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [BYTE_W-1:0] push_byte;
  logic [DISC_W-1:0] discard_count;

  modport source (output valid, output action, output push_byte, output discard_count,
                  input ready);
  modport sink   (input valid, input action, input push_byte, input discard_count,
                  output ready);
endinterface

// ----- rtl/bfo_out_if.sv -----
// Result channel of the byte FIFO: valid, ready and one result word.
// Depends on bfo_pkg.
interface bfo_out_if import bfo_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              done_res;
  logic [BYTE_W-1:0] front_byte;
  logic [CNT_W-1:0]  fill_level;
  logic [DROP_W-1:0] dropped_total;

  modport source (output valid, output done_res, output front_byte, output fill_level,
                  output dropped_total, input ready);
  modport sink   (input valid, input done_res, input front_byte, input fill_level,
                  input dropped_total, output ready);
endinterface

// ----- rtl/byte_fifo_with_overflow_policy_top.sv -----
// Byte FIFO with programmable capacity and overflow policy (block, drop newest, drop oldest).
// A request is accepted in S_IDLE; S_READ registers its result word once the output register
// is free, using the registered read port of the byte store. Ready is low in S_READ.
// A new request is taken while the previous result still waits in the output register.
// Reset clears front, fill, drops and res_valid, resets cap and mode; byte store not cleared.
// Depends on bfo_pkg, bfo_in_if and bfo_out_if.
module byte_fifo_with_overflow_policy_top import bfo_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  bfo_in_if.sink               req,
  bfo_out_if.source            res
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int FW = (AW < CNT_W) ? AW : CNT_W;
  localparam logic [16:0] DEPTH_W = 17'(STORE_DEPTH);
  localparam logic [CNT_W-1:0] CAP_RST =
    CNT_W'((CAP_RESET > STORE_DEPTH) ? STORE_DEPTH : CAP_RESET);

  typedef enum logic [0:0] {
    S_IDLE,
    S_READ
  } state_t;

  state_t              state;
  logic [FW-1:0]       front;
  logic [CNT_W-1:0]    held;
  logic [DROP_W-1:0]   drop;
  logic [CNT_W-1:0]    cap;
  logic [MODE_W-1:0]   mode;

  logic                pend_done;
  logic                pend_mem;

  logic                res_valid;
  logic                res_done;
  logic [BYTE_W-1:0]   res_byte;
  logic [CNT_W-1:0]    res_fill;
  logic [DROP_W-1:0]   res_drop;

  logic [BYTE_W-1:0]   mem [STORE_DEPTH];
  logic [BYTE_W-1:0]   rdata;

  logic                accept;
  logic [FW-1:0]       front_next;
  logic [CNT_W-1:0]    held_next;
  logic [DROP_W-1:0]   drop_next;
  logic                done_next;
  logic                mem_next;
  logic                mem_we;
  logic [AW-1:0]       waddr;
  logic [CNT_W-1:0]    cap_wr;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);

  assign cap_wr = (17'(cfg_data) > DEPTH_W) ? CNT_W'(STORE_DEPTH) : cfg_data;

  always_comb begin
    logic [CNT_W-1:0] front_ext;
    logic [CNT_W:0]   cap_ext;
    logic [CNT_W:0]   adv_sum;
    logic [CNT_W:0]   adv_wrap;
    logic [CNT_W:0]   tail_sum;
    logic [CNT_W:0]   tail_wrap;
    logic [CNT_W-1:0] adv_n;
    logic [CNT_W-1:0] disc_n;
    logic             drop_inc;
    logic             store_new;
    logic             full_evict;

    front_ext  = CNT_W'(front);
    cap_ext    = (CNT_W+1)'(cap);
    disc_n     = (req.discard_count < DISC_W'(held)) ? CNT_W'(req.discard_count) : held;
    adv_n      = '0;
    drop_inc   = 1'b0;
    store_new  = 1'b0;
    full_evict = 1'b0;
    done_next  = 1'b0;
    mem_next   = 1'b0;
    front_next = front;
    held_next  = held;

    case (req.action)
      ACT_PUSH: begin
        if (cap == '0) begin
          drop_inc = (mode == MODE_DROP_NEW) || (mode == MODE_DROP_OLD);
        end else if (held < cap) begin
          store_new = 1'b1;
          done_next = 1'b1;
        end else if (mode == MODE_DROP_NEW) begin
          drop_inc = 1'b1;
        end else if (mode == MODE_DROP_OLD) begin
          drop_inc   = 1'b1;
          full_evict = 1'b1;
          adv_n      = CNT_W'(1);
          done_next  = 1'b1;
        end
      end
      ACT_POP: begin
        if (held != '0) begin
          adv_n     = CNT_W'(1);
          done_next = 1'b1;
          mem_next  = 1'b1;
        end
      end
      ACT_PEEK: begin
        if (held != '0) begin
          done_next = 1'b1;
          mem_next  = 1'b1;
        end
      end
      ACT_DISCARD: begin
        adv_n = disc_n;
      end
      ACT_CLEAR: begin
        front_next = '0;
        held_next  = '0;
      end
      default: begin
      end
    endcase

    adv_sum  = (CNT_W+1)'(front_ext) + (CNT_W+1)'(adv_n);
    adv_wrap = (adv_sum >= cap_ext) ? adv_sum - cap_ext : adv_sum;
    if (adv_n != '0 && cap != '0) begin
      front_next = FW'(adv_wrap);
      if (!full_evict) begin
        held_next = held - adv_n;
      end
    end

    tail_sum  = (CNT_W+1)'(front_ext) + (CNT_W+1)'(held);
    tail_wrap = (tail_sum >= cap_ext) ? tail_sum - cap_ext : tail_sum;
    if (store_new) begin
      held_next = held + CNT_W'(1);
    end
    mem_we = accept && (store_new || full_evict);
    waddr  = full_evict ? AW'(front) : AW'(tail_wrap);

    drop_next = (drop_inc && drop != '1) ? drop + DROP_W'(1) : drop;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= req.push_byte;
    end
    if (accept && mem_next) begin
      rdata <= mem[AW'(front)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      held      <= '0;
      drop      <= '0;
      cap       <= CAP_RST;
      mode      <= MODE_BLOCK;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CAPACITY: begin
            cap   <= cap_wr;
            front <= '0;
            held  <= '0;
          end
          REG_MODE: mode <= cfg_data[MODE_W-1:0];
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            front     <= front_next;
            held      <= held_next;
            drop      <= drop_next;
            pend_done <= done_next;
            pend_mem  <= mem_next;
            state     <= S_READ;
          end
        end
        S_READ: begin
          if (!res_valid || res.ready) begin
            res_valid <= 1'b1;
            res_done  <= pend_done;
            res_byte  <= pend_mem ? rdata : '0;
            res_fill  <= held;
            res_drop  <= drop;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid         = res_valid;
  assign res.done_res      = res_done;
  assign res.front_byte    = res_byte;
  assign res.fill_level    = res_fill;
  assign res.dropped_total = res_drop;

  a_fill_in_cap: assert property (@(posedge clk) disable iff (rst) held <= cap)
    else $error("fill above capacity");

  a_front_in_cap: assert property (@(posedge clk) disable iff (rst)
    held == '0 || CNT_W'(front) < cap)
    else $error("front index outside capacity");

  a_no_byte_when_not_done: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_done |-> res_byte == '0)
    else $error("front byte returned without a hit");

  a_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_READ && !req.ready)
    else $error("request taken while another is in flight");

endmodule
